// File: design/tspat_pkg.sv
// Package for the transport stream PAT section parser.
// Holds the byte and record transaction types, record kinds, reject causes and constants.
// No dependencies.
package tspat_pkg;

  localparam int DEFAULT_PACKET_BYTES = 188;

  localparam logic [7:0] TS_SYNC = 8'h47;
  localparam logic [11:0] MIN_SECTION_LEN = 12'd9;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_TRAILER = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [2:0] CAUSE_NONE = 3'd0;
  localparam logic [2:0] CAUSE_SYNC = 3'd1;
  localparam logic [2:0] CAUSE_NOT_PAT = 3'd2;
  localparam logic [2:0] CAUSE_ADAPT = 3'd3;
  localparam logic [2:0] CAUSE_OVERRUN = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } tspat_byte_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [15:0] prog_num;
    logic [12:0] map_pid;
    logic [7:0]  tbl_id;
    logic [15:0] stream_id;
    logic [4:0]  version;
    logic        current_next;
    logic [7:0]  section_index;
    logic [7:0]  last_section_index;
    logic [31:0] crc_value;
    logic [2:0]  reject_cause;
  } tspat_rec_t;

endpackage

// File: design/ts_pat_section_parser.sv
// Top level of the transport stream PAT section parser.
// Instantiates tspat_in_stage, tspat_parser and tspat_out_stage; depends on tspat_pkg.
//
// The parser takes one transport stream byte per clock and sustains that rate
// indefinitely while the record consumer keeps up. Each accepted byte transaction
// passes through the input register, is parsed by combinational logic against the
// packet state, and its record, if any, is loaded into the result register when
// the held byte advances. A stall on the record side holds the whole two-stage
// pipeline, so byte_stall rises only while a record is waiting.
// Program entry records come out on the last byte of each entry, the trailer on
// the last CRC byte (the CRC is reported, not checked), and reject records on the
// byte that decides the rejection; after a reject or trailer, bytes are ignored
// until the next packet_start.
module ts_pat_section_parser #(
  parameter int PACKET_BYTES = tspat_pkg::DEFAULT_PACKET_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  tspat_pkg::tspat_byte_t byte_item,
  output logic                   rec_valid,
  input  logic                   rec_stall,
  output tspat_pkg::tspat_rec_t  rec_item
);
  import tspat_pkg::*;

  logic        advance;
  logic        held_valid;
  tspat_byte_t held_item;
  logic        fire;
  logic        emit;
  tspat_rec_t  rec;

  assign fire = held_valid && advance;

  tspat_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  tspat_parser #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (held_item),
    .emit (emit),
    .rec  (rec)
  );

  tspat_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .emit      (emit),
    .rec       (rec),
    .advance   (advance),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec_item  (rec_item)
  );

  a_stall_only_when_backed_up: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (rec_valid && rec_stall))
    else $error("byte side stalled while the result register can drain");

  a_reject_has_cause: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec_item.record_kind == KIND_REJECT) |-> (rec_item.reject_cause != CAUSE_NONE))
    else $error("reject record without a cause");

  a_no_cause_otherwise: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec_item.record_kind != KIND_REJECT) |-> (rec_item.reject_cause == CAUSE_NONE))
    else $error("entry or trailer record carries a reject cause");

  a_entry_no_trailer_fields: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec_item.record_kind == KIND_ENTRY) |->
      (rec_item.tbl_id == 8'd0 && rec_item.crc_value == 32'd0))
    else $error("entry record carries trailer fields");

endmodule

// File: design/tspat_in_stage.sv
// Input register of the PAT parser: captures one byte transaction per cycle while byte_stall is low.
// Depends on tspat_pkg for the byte transaction type.
module tspat_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  tspat_pkg::tspat_byte_t byte_item,
  input  logic                 advance,
  output logic                 held_valid,
  output tspat_pkg::tspat_byte_t held_item
);
  import tspat_pkg::*;

  logic take;

  assign byte_stall = held_valid && !advance;
  assign take = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_item <= byte_item;
    end
  end

endmodule

// File: design/tspat_parser.sv
// Parse state of the PAT parser: packet header, adaptation and pointer skips, section fields.
// Produces at most one record per byte. Depends on tspat_pkg.
module tspat_parser #(
  parameter int PACKET_BYTES = tspat_pkg::DEFAULT_PACKET_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  tspat_pkg::tspat_byte_t item,
  output logic                   emit,
  output tspat_pkg::tspat_rec_t  rec
);
  import tspat_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_ADAPT_LEN = 3'd2;
  localparam logic [2:0] PH_ADAPT_SKIP = 3'd3;
  localparam logic [2:0] PH_POINTER = 3'd4;
  localparam logic [2:0] PH_PTR_SKIP = 3'd5;
  localparam logic [2:0] PH_SECTION = 3'd6;

  localparam logic [12:0] PKT = 13'(PACKET_BYTES);

  logic [2:0]  phase, phase_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  skip_count, skip_count_next;
  logic [11:0] section_size, section_size_next;
  logic [11:0] section_offset, section_offset_next;
  logic [47:0] header_fields, header_fields_next;
  logic [23:0] entry_bytes, entry_bytes_next;
  logic [31:0] crc_shift, crc_shift_next;

  logic [7:0]  b;
  logic [7:0]  pos_inc;
  logic [11:0] sl;
  logic [11:0] entry_off;
  logic [11:0] avail;
  logic [1:0]  mode;
  logic        rej;
  logic [2:0]  cause;

  assign b = item.data_byte;

  always_comb begin
    phase_next = phase;
    byte_position_next = byte_position;
    skip_count_next = skip_count;
    section_size_next = section_size;
    section_offset_next = section_offset;
    header_fields_next = header_fields;
    entry_bytes_next = entry_bytes;
    crc_shift_next = crc_shift;
    emit = 1'b0;
    rec = '0;
    rej = 1'b0;
    cause = CAUSE_NONE;
    pos_inc = (byte_position != 8'hFF) ? byte_position + 8'd1 : byte_position;
    sl = section_size | {4'h0, b};
    if (sl < MIN_SECTION_LEN) begin
      sl = MIN_SECTION_LEN;
    end
    entry_off = section_offset - 12'd8;
    avail = section_size - MIN_SECTION_LEN;
    mode = b[5:4];

    if (item.packet_start) begin
      byte_position_next = '0;
      skip_count_next = '0;
      section_size_next = '0;
      section_offset_next = '0;
      header_fields_next = '0;
      entry_bytes_next = '0;
      crc_shift_next = '0;
      if (b != TS_SYNC) begin
        rej = 1'b1;
        cause = CAUSE_SYNC;
      end else begin
        phase_next = PH_HEADER;
      end
    end else begin
      byte_position_next = pos_inc;
      case (phase)
        PH_IDLE: begin
        end
        PH_HEADER: begin
          if (pos_inc < 8'd3) begin
            entry_bytes_next = {8'h00, entry_bytes[7:0], b};
          end else begin
            entry_bytes_next = '0;
            if (!entry_bytes[14] || entry_bytes[12:0] != 13'd0) begin
              rej = 1'b1;
              cause = CAUSE_NOT_PAT;
            end else if (mode == 2'd1) begin
              phase_next = PH_POINTER;
            end else if (mode == 2'd3) begin
              phase_next = PH_ADAPT_LEN;
            end else begin
              rej = 1'b1;
              cause = CAUSE_ADAPT;
            end
          end
        end
        PH_ADAPT_LEN: begin
          if ({5'd0, pos_inc} + {5'd0, b} + 13'd14 > PKT) begin
            rej = 1'b1;
            cause = CAUSE_OVERRUN;
          end else if (b == 8'd0) begin
            phase_next = PH_POINTER;
          end else begin
            skip_count_next = b;
            phase_next = PH_ADAPT_SKIP;
          end
        end
        PH_ADAPT_SKIP: begin
          skip_count_next = skip_count - 8'd1;
          if (skip_count == 8'd1) begin
            phase_next = PH_POINTER;
          end
        end
        PH_POINTER: begin
          if ({5'd0, pos_inc} + {5'd0, b} + 13'd13 > PKT) begin
            rej = 1'b1;
            cause = CAUSE_OVERRUN;
          end else begin
            section_offset_next = '0;
            if (b == 8'd0) begin
              phase_next = PH_SECTION;
            end else begin
              skip_count_next = b;
              phase_next = PH_PTR_SKIP;
            end
          end
        end
        PH_PTR_SKIP: begin
          skip_count_next = skip_count - 8'd1;
          if (skip_count == 8'd1) begin
            phase_next = PH_SECTION;
          end
        end
        PH_SECTION: begin
          section_offset_next = section_offset + 12'd1;
          if (section_offset < 12'd8) begin
            case (section_offset[2:0])
              3'd0: header_fields_next[47:40] = b;
              3'd1: section_size_next = {b[3:0], 8'h00};
              3'd2: begin
                section_size_next = sl;
                if ({5'd0, pos_inc} + {1'b0, sl} > PKT - 13'd1) begin
                  rej = 1'b1;
                  cause = CAUSE_OVERRUN;
                end
              end
              3'd3: header_fields_next[39:32] = b;
              3'd4: header_fields_next[31:24] = b;
              3'd5: header_fields_next[23:16] = b;
              3'd6: header_fields_next[15:8] = b;
              default: header_fields_next[7:0] = b;
            endcase
          end else if ({1'b0, section_offset} + 13'd1 >= {1'b0, section_size}) begin
            crc_shift_next = {crc_shift[23:0], b};
            if ({1'b0, section_offset} == {1'b0, section_size} + 13'd2) begin
              emit = 1'b1;
              rec.record_kind = KIND_TRAILER;
              rec.tbl_id = header_fields[47:40];
              rec.stream_id = header_fields[39:24];
              rec.version = header_fields[21:17];
              rec.current_next = header_fields[16];
              rec.section_index = header_fields[15:8];
              rec.last_section_index = header_fields[7:0];
              rec.crc_value = {crc_shift[23:0], b};
              phase_next = PH_IDLE;
            end
          end else if (entry_off[1:0] == 2'b11 &&
                       {1'b0, entry_off} + 13'd1 <= {1'b0, avail}) begin
            emit = 1'b1;
            rec.record_kind = KIND_ENTRY;
            rec.prog_num = entry_bytes[23:8];
            rec.map_pid = {entry_bytes[4:0], b};
            entry_bytes_next = '0;
          end else begin
            entry_bytes_next = {entry_bytes[15:0], b};
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    if (rej) begin
      emit = 1'b1;
      rec = '0;
      rec.record_kind = KIND_REJECT;
      rec.reject_cause = cause;
      phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      byte_position <= '0;
      skip_count <= '0;
      section_size <= '0;
      section_offset <= '0;
      header_fields <= '0;
      entry_bytes <= '0;
      crc_shift <= '0;
    end else if (fire) begin
      phase <= phase_next;
      byte_position <= byte_position_next;
      skip_count <= skip_count_next;
      section_size <= section_size_next;
      section_offset <= section_offset_next;
      header_fields <= header_fields_next;
      entry_bytes <= entry_bytes_next;
      crc_shift <= crc_shift_next;
    end
  end

endmodule

// File: design/tspat_out_stage.sv
// Result register of the PAT parser: holds one record until the consumer takes it.
// Depends on tspat_pkg for the record transaction type.
module tspat_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic                  emit,
  input  tspat_pkg::tspat_rec_t rec,
  output logic                  advance,
  output logic                  rec_valid,
  input  logic                  rec_stall,
  output tspat_pkg::tspat_rec_t rec_item
);
  import tspat_pkg::*;

  assign advance = !rec_valid || !rec_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (advance) begin
      rec_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire && emit) begin
      rec_item <= rec;
    end
  end

endmodule
